@@ hw/rtl/d96r_pkg.sv @@
// ----------------------------------------------------------------------------
// d96r_pkg: shared definitions for the decimal96 round unit
// Field widths, operation codes and the divide-by-ten reciprocal.
// ----------------------------------------------------------------------------
package d96r_pkg;

   localparam int unsigned MANT_W   = 96;
   localparam int unsigned LIMB_W   = 32;
   localparam int unsigned LIMB_N   = MANT_W / LIMB_W;
   localparam int unsigned IDX_W    = 2;
   localparam int unsigned SCALE_IN_W = 8;
   localparam int unsigned SCALE_W  = 5;
   localparam int unsigned DIGIT_W  = 4;

   localparam logic [SCALE_IN_W-1:0] MAX_SCALE = 8'd28;
   localparam logic [DIGIT_W-1:0]    RADIX     = 4'd10;
   localparam logic [DIGIT_W-1:0]    HALF_DIGIT = 4'd5;

   // numerator of one step is {remainder, limb}, below 10 * 2^32 < 2^36
   localparam int unsigned NUM_W     = LIMB_W + DIGIT_W;
   localparam int unsigned RECIP_W   = 33;
   localparam int unsigned PROD_W    = NUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] DIV_RECIP = 33'd6871947673; // floor(2^36 / 10)

   localparam logic [1:0] FUNC_FLOOR = 2'd0;
   localparam logic [1:0] FUNC_ROUND = 2'd1;
   localparam logic [1:0] FUNC_TRUNC = 2'd2;
   localparam logic [1:0] FUNC_NEG   = 2'd3;

endpackage

@@ hw/rtl/d96r_req_if.sv @@
// ----------------------------------------------------------------------------
// d96r_req_if: request channel of the decimal96 round unit
// Valid/ready handshake carrying one decimal operand and its operation.
// ----------------------------------------------------------------------------
interface d96r_req_if import d96r_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            func;
   logic [63:0]           mant_low;
   logic [31:0]           mant_high;
   logic [SCALE_IN_W-1:0] scale_in;
   logic                  sign_in;

   modport source (output valid, func, mant_low, mant_high, scale_in, sign_in,
                   input ready);
   modport sink   (input valid, func, mant_low, mant_high, scale_in, sign_in,
                   output ready);
endinterface

@@ hw/rtl/d96r_rsp_if.sv @@
// ----------------------------------------------------------------------------
// d96r_rsp_if: response channel of the decimal96 round unit
// Valid/ready handshake carrying one result (mantissa, scale, sign) and its bad-input flag.
// ----------------------------------------------------------------------------
interface d96r_rsp_if import d96r_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [63:0]        res_low;
   logic [31:0]        res_high;
   logic [SCALE_W-1:0] res_scale;
   logic               res_sign;
   logic               bad_input;

   modport source (output valid, res_low, res_high, res_scale, res_sign, bad_input,
                   input ready);
   modport sink   (input valid, res_low, res_high, res_scale, res_sign, bad_input,
                   output ready);
endinterface

@@ hw/rtl/d96r_div10.sv @@
// ----------------------------------------------------------------------------
// d96r_div10: one limb step of a long division by ten
// Divides {rem_in, limb_in} by ten with a reciprocal multiply and one
// correction; the remainder feeds the next lower limb.
// ----------------------------------------------------------------------------
module d96r_div10 import d96r_pkg::*; (
   input  logic [LIMB_W-1:0]  limb_in,
   input  logic [DIGIT_W-1:0] rem_in,
   output logic [LIMB_W-1:0]  quot,
   output logic [DIGIT_W-1:0] rem_out
);
   logic [NUM_W-1:0]  num;
   logic [PROD_W-1:0] prod;
   logic [LIMB_W-1:0] q_est;
   logic [NUM_W-1:0]  q_x10;
   logic [NUM_W-1:0]  r_est;
   logic              fix;

   assign num   = {rem_in, limb_in};
   assign prod  = PROD_W'(num) * PROD_W'(DIV_RECIP);
   // estimate is exact or one short
   assign q_est = prod[NUM_W +: LIMB_W];
   assign q_x10 = {1'b0, q_est, 3'b000} + {3'b000, q_est, 1'b0};
   assign r_est = num - q_x10;
   assign fix   = (r_est >= NUM_W'(RADIX));

   assign quot    = q_est + LIMB_W'(fix);
   assign rem_out = fix ? DIGIT_W'(r_est - NUM_W'(RADIX)) : DIGIT_W'(r_est);
endmodule

@@ hw/rtl/decimal96_round_unit.sv @@
// ----------------------------------------------------------------------------
// decimal96_round_unit: floor / round-half-even / truncate / negate
// Reduces a sign-magnitude decimal (96-bit mantissa, scale, sign) to an
// integer, or negates it.
//
// req_chan takes one operand transaction when valid and ready are high;
// ready is high only while the sequencer is idle. rsp_chan returns exactly
// one result transaction per request, in order.
// Each scale step divides the mantissa by ten on a shared 32-bit limb
// divider, one limb per cycle, from the top limb down. Negate, a scale of
// zero or a scale above 28 skip the divide steps and go straight to the
// final state. Once the result register is loaded the sequencer returns
// to idle and can take the next request.
// The result sits in an output register: a new request can be accepted
// and worked on while rsp_chan is stalled; the sequencer only waits in its
// final state until that register is free.
// Synchronous reset returns the sequencer to idle and drops rsp valid.
// ----------------------------------------------------------------------------
module decimal96_round_unit import d96r_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   d96r_req_if.sink   req_chan,
   d96r_rsp_if.source rsp_chan
);
   typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_FIX} state_type;

   state_type             state_ff, state_in;
   logic [MANT_W-1:0]     mant_ff, mant_in;
   logic [1:0]            func_ff, func_in;
   logic                  sign_ff, sign_in;
   logic [SCALE_W-1:0]    scale_ff, scale_in;
   logic                  bad_ff, bad_in;
   logic [SCALE_W-1:0]    cnt_ff, cnt_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [DIGIT_W-1:0]    rem_ff, rem_in;
   logic [DIGIT_W-1:0]    top_ff, top_in;
   logic                  sticky_ff, sticky_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [MANT_W-1:0]     rsp_mant_ff, rsp_mant_in;
   logic [SCALE_W-1:0]    rsp_scale_ff, rsp_scale_in;
   logic                  rsp_sign_ff, rsp_sign_in;
   logic                  rsp_bad_ff, rsp_bad_in;

   logic [LIMB_W-1:0]     limb_cur;
   logic [LIMB_W-1:0]     quot;
   logic [DIGIT_W-1:0]    digit;
   logic                  bump;
   logic                  round_up;
   logic [MANT_W-1:0]     mant_sum;

   always_comb begin
      unique case (idx_ff)
         2'd0:    limb_cur = mant_ff[0 +: LIMB_W];
         2'd1:    limb_cur = mant_ff[LIMB_W +: LIMB_W];
         default: limb_cur = mant_ff[2*LIMB_W +: LIMB_W];
      endcase
   end

   d96r_div10 u_div10 (
      .limb_in (limb_cur),
      .rem_in  (rem_ff),
      .quot    (quot),
      .rem_out (digit)
   );

   // round half even on the whole discarded fraction
   assign round_up = (top_ff > HALF_DIGIT) ||
                     ((top_ff == HALF_DIGIT) && (sticky_ff || mant_ff[0]));

   always_comb begin
      unique case (func_ff)
         FUNC_FLOOR: bump = sign_ff && ((top_ff != '0) || sticky_ff);
         FUNC_ROUND: bump = round_up;
         default:    bump = 1'b0;
      endcase
   end

   assign mant_sum = mant_ff + MANT_W'(bump);

   always_comb begin
      state_in     = state_ff;
      mant_in      = mant_ff;
      func_in      = func_ff;
      sign_in      = sign_ff;
      scale_in     = scale_ff;
      bad_in       = bad_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      rem_in       = rem_ff;
      top_in       = top_ff;
      sticky_in    = sticky_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_mant_in  = rsp_mant_ff;
      rsp_scale_in = rsp_scale_ff;
      rsp_sign_in  = rsp_sign_ff;
      rsp_bad_in   = rsp_bad_ff;

      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               mant_in   = {req_chan.mant_high, req_chan.mant_low};
               func_in   = req_chan.func;
               sign_in   = req_chan.sign_in;
               scale_in  = req_chan.scale_in[SCALE_W-1:0];
               cnt_in    = req_chan.scale_in[SCALE_W-1:0];
               bad_in    = (req_chan.scale_in > MAX_SCALE);
               idx_in    = IDX_W'(LIMB_N - 1);
               rem_in    = '0;
               top_in    = '0;
               sticky_in = 1'b0;
               if ((req_chan.scale_in > MAX_SCALE) || (req_chan.func == FUNC_NEG) ||
                   (req_chan.scale_in == '0)) begin
                  state_in = ST_FIX;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            mant_in[idx_ff*LIMB_W +: LIMB_W] = quot;
            if (idx_ff == '0) begin
               // digit complete: previous top digit folds into sticky
               sticky_in = sticky_ff || (top_ff != '0);
               top_in    = digit;
               rem_in    = '0;
               idx_in    = IDX_W'(LIMB_N - 1);
               cnt_in    = cnt_ff - SCALE_W'(1);
               if (cnt_ff == SCALE_W'(1)) begin
                  state_in = ST_FIX;
               end
            end else begin
               rem_in = digit;
               idx_in = idx_ff - IDX_W'(1);
            end
         end
         ST_FIX: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_bad_in   = bad_ff;
               if (bad_ff) begin
                  rsp_mant_in  = '0;
                  rsp_scale_in = '0;
                  rsp_sign_in  = 1'b0;
               end else begin
                  rsp_mant_in  = mant_sum;
                  rsp_scale_in = (func_ff == FUNC_NEG) ? scale_ff : '0;
                  unique case (func_ff)
                     FUNC_NEG:   rsp_sign_in = !sign_ff;
                     FUNC_TRUNC: rsp_sign_in = sign_ff && (mant_ff != '0);
                     default:    rsp_sign_in = sign_ff;
                  endcase
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mant_ff      <= mant_in;
      func_ff      <= func_in;
      sign_ff      <= sign_in;
      scale_ff     <= scale_in;
      bad_ff       <= bad_in;
      cnt_ff       <= cnt_in;
      idx_ff       <= idx_in;
      rem_ff       <= rem_in;
      top_ff       <= top_in;
      sticky_ff    <= sticky_in;
      rsp_mant_ff  <= rsp_mant_in;
      rsp_scale_ff <= rsp_scale_in;
      rsp_sign_ff  <= rsp_sign_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.res_low   = rsp_mant_ff[63:0];
   assign rsp_chan.res_high  = rsp_mant_ff[MANT_W-1:64];
   assign rsp_chan.res_scale = rsp_scale_ff;
   assign rsp_chan.res_sign  = rsp_sign_ff;
   assign rsp_chan.bad_input = rsp_bad_ff;

   a_div_cnt_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff != '0))
      else $error("divide running with no scale steps left");

   a_rem_digit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < RADIX) && (top_ff < RADIX))
      else $error("remainder or discarded digit out of decimal range");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> ((rsp_mant_ff == '0) && (rsp_scale_ff == '0)
                                        && !rsp_sign_ff))
      else $error("invalid-scale result is not zero");

   a_fix_to_rsp: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FIX) && (!rsp_valid_ff || rsp_chan.ready)) |=> rsp_valid_ff)
      else $error("finished transaction did not reach the result register");

endmodule
